/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the dma sequencer checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/fcds_pkg.sv */
// ----------------------------------------------------------------------------
// fcds_pkg
// types, codes and helpers shared by the four-channel dma sequencer modules
// ----------------------------------------------------------------------------
package fcds_pkg;

	// input item kinds
	localparam logic [2:0] K_SRC   = 3'd0;
	localparam logic [2:0] K_DST   = 3'd1;
	localparam logic [2:0] K_COUNT = 3'd2;
	localparam logic [2:0] K_CTL   = 3'd3;
	localparam logic [2:0] K_VBL   = 3'd4;
	localparam logic [2:0] K_HBL   = 3'd5;
	localparam logic [2:0] K_STEP  = 3'd6;

	// control register bits
	localparam int CTL_EN     = 15;
	localparam int CTL_IRQ    = 14;
	localparam int CTL_WORD   = 10;
	localparam int CTL_REPEAT = 9;

	// start timing codes
	localparam logic [1:0] TIM_NOW = 2'd0;
	localparam logic [1:0] TIM_VBL = 2'd1;
	localparam logic [1:0] TIM_HBL = 2'd2;

	// address adjust codes
	localparam logic [1:0] ADJ_UP     = 2'd0;
	localparam logic [1:0] ADJ_DOWN   = 2'd1;
	localparam logic [1:0] ADJ_RELOAD = 2'd3;

	// block lengths for a zero count
	localparam logic [16:0] LEN_ZERO      = 17'h04000;
	localparam logic [16:0] LEN_ZERO_LAST = 17'h10000;

	// memory operations carried to stage 1
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_REG  = 2'd1;
	localparam logic [1:0] OP_ACT  = 2'd2;
	localparam logic [1:0] OP_UNIT = 2'd3;

	typedef struct packed {
		logic [31:0] src_reg;
		logic [31:0] dst_reg;
		logic [31:0] work_src;
		logic [31:0] work_dst;
		logic [31:0] dest_start;
	} entry_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        dst_sel;
		logic [15:0] ctl;
		logic        fresh;
		logic        last;
		logic        reload;
		logic [31:0] value;
	} cmd_t;

	function automatic logic [1:0] timing_of(logic [15:0] ctl);
		return ctl[13:12];
	endfunction

	function automatic logic [1:0] src_adj_of(logic [15:0] ctl);
		return ctl[8:7];
	endfunction

	function automatic logic [1:0] dst_adj_of(logic [15:0] ctl);
		return ctl[6:5];
	endfunction

	function automatic logic [16:0] block_len(logic [15:0] cnt, logic long_ch);
		logic [16:0] len;
		if (cnt != 16'd0) begin
			len = {1'b0, cnt};
		end else if (long_ch) begin
			len = LEN_ZERO_LAST;
		end else begin
			len = LEN_ZERO;
		end
		return len;
	endfunction

endpackage

/* sv/fcds_ram.sv */
// ----------------------------------------------------------------------------
// fcds_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module fcds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/fcds_ctrl.sv */
// ----------------------------------------------------------------------------
// fcds_ctrl
// per-channel control state, event start logic and step arbitration
// ----------------------------------------------------------------------------
module fcds_ctrl import fcds_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [2:0]                  kind,
	input  logic [$clog2(CHANNELS)-1:0] channel,
	input  logic [31:0]                 value,
	output cmd_t                        cmd,
	output logic [$clog2(CHANNELS)-1:0] cmd_ch
);

	localparam int CW = $clog2(CHANNELS);

	logic [15:0]         ctl_q   [CHANNELS];
	logic [15:0]         count_q [CHANNELS];
	logic [16:0]         units_q [CHANNELS];
	logic [CHANNELS-1:0] active_q;
	logic [CHANNELS-1:0] pending_q;
	logic [CHANNELS-1:0] fresh_q;

	logic [15:0]         ctl_d   [CHANNELS];
	logic [15:0]         count_d [CHANNELS];
	logic [16:0]         units_d [CHANNELS];
	logic [CHANNELS-1:0] active_d;
	logic [CHANNELS-1:0] pending_d;
	logic [CHANNELS-1:0] fresh_d;

	logic [CW-1:0] sel;
	logic          found;
	logic [15:0]   c;
	logic [16:0]   left;
	logic [1:0]    ev_tim;

	always_comb begin
		ctl_d     = ctl_q;
		count_d   = count_q;
		units_d   = units_q;
		active_d  = active_q;
		pending_d = pending_q;
		fresh_d   = fresh_q;
		cmd       = '0;
		cmd.value = value;
		cmd_ch    = channel;
		sel       = '0;
		found     = 1'b0;
		c         = '0;
		left      = '0;
		ev_tim    = (kind == K_VBL) ? TIM_VBL : TIM_HBL;

		for (int i = 0; i < CHANNELS; i++) begin
			if (!found && pending_q[i]) begin
				found = 1'b1;
				sel   = CW'(i);
			end
		end

		if (accept) begin
			case (kind)
				K_SRC: begin
					cmd.op = OP_REG;
				end
				K_DST: begin
					cmd.op      = OP_REG;
					cmd.dst_sel = 1'b1;
				end
				K_COUNT: begin
					count_d[channel] = value[15:0];
				end
				K_CTL: begin
					ctl_d[channel] = value[15:0];
					if (!value[CTL_EN]) begin
						active_d[channel]  = 1'b0;
						pending_d[channel] = 1'b0;
					end else if (!active_q[channel]) begin
						active_d[channel] = 1'b1;
						cmd.op            = OP_ACT;
						if (timing_of(value[15:0]) == TIM_NOW) begin
							units_d[channel]   = block_len(count_q[channel],
								channel == CW'(CHANNELS - 1));
							pending_d[channel] = 1'b1;
							fresh_d[channel]   = 1'b1;
						end
					end
				end
				K_VBL, K_HBL: begin
					for (int i = 0; i < CHANNELS; i++) begin
						if (active_q[i] && !pending_q[i] && ctl_q[i][CTL_EN] &&
							timing_of(ctl_q[i]) == ev_tim) begin
							units_d[i]   = block_len(count_q[i], i == CHANNELS - 1);
							pending_d[i] = 1'b1;
							fresh_d[i]   = 1'b1;
						end
					end
				end
				K_STEP: begin
					if (found) begin
						c            = ctl_q[sel];
						left         = units_q[sel] - 17'd1;
						units_d[sel] = left;
						fresh_d[sel] = 1'b0;
						cmd.op       = OP_UNIT;
						cmd.ctl      = c;
						cmd.fresh    = fresh_q[sel];
						cmd.last     = (left == 17'd0);
						cmd_ch       = sel;
						if (left == 17'd0) begin
							pending_d[sel] = 1'b0;
							if (c[CTL_REPEAT] && timing_of(c) != TIM_NOW) begin
								cmd.reload = (dst_adj_of(c) == ADJ_RELOAD);
							end else begin
								ctl_d[sel][CTL_EN] = 1'b0;
								active_d[sel]      = 1'b0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				ctl_q[i]   <= '0;
				count_q[i] <= '0;
				units_q[i] <= '0;
			end
			active_q  <= '0;
			pending_q <= '0;
			fresh_q   <= '0;
		end else begin
			ctl_q     <= ctl_d;
			count_q   <= count_d;
			units_q   <= units_d;
			active_q  <= active_d;
			pending_q <= pending_d;
			fresh_q   <= fresh_d;
		end
	end

endmodule

/* sv/fcds_datapath.sv */
// ----------------------------------------------------------------------------
// fcds_datapath
// address memory read-modify-write with forwarding, and the result register
// ----------------------------------------------------------------------------
module fcds_datapath import fcds_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  cmd_t                        cmd,
	input  logic [$clog2(CHANNELS)-1:0] cmd_ch,
	input  logic                        out_stall,
	output logic                        hold,
	output logic                        out_valid,
	output logic [$clog2(CHANNELS)-1:0] unit_channel,
	output logic [31:0]                 read_address,
	output logic [31:0]                 write_address,
	output logic                        word_size,
	output logic                        last,
	output logic [CHANNELS-1:0]         irq_mask
);

	localparam int CW = $clog2(CHANNELS);
	localparam int EW = $bits(entry_t);

	logic [1:0]    op_s1;
	cmd_t          cmd_s1;
	logic [CW-1:0] ch_s1;

	logic [CHANNELS-1:0] written_q;
	logic                fwd_ok_q;
	logic [CW-1:0]       fwd_addr_q;
	entry_t              fwd_data_q;
	logic                out_valid_q;

	logic   adv;
	logic   we;
	entry_t ram_rdata;
	entry_t cur;
	entry_t nxt;
	logic [31:0] step;
	logic [31:0] dstart;

	assign adv  = !(out_valid_q && out_stall);
	assign hold = !adv;
	assign we   = adv && (op_s1 != OP_NONE);

	fcds_ram #(
		.WIDTH(EW),
		.DEPTH(CHANNELS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(ch_s1),
		.wdata(nxt),
		.re   (accept),
		.raddr(cmd_ch),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (fwd_ok_q && fwd_addr_q == ch_s1) begin
			cur = fwd_data_q;
		end else if (written_q[ch_s1]) begin
			cur = ram_rdata;
		end else begin
			cur = '0;
		end

		step   = cmd_s1.ctl[CTL_WORD] ? 32'd4 : 32'd2;
		dstart = cmd_s1.fresh ? cur.work_dst : cur.dest_start;
		nxt    = cur;

		case (op_s1)
			OP_REG: begin
				if (cmd_s1.dst_sel) begin
					nxt.dst_reg = cmd_s1.value;
				end else begin
					nxt.src_reg = cmd_s1.value;
				end
			end
			OP_ACT: begin
				nxt.work_src = cur.src_reg;
				nxt.work_dst = cur.dst_reg;
			end
			OP_UNIT: begin
				nxt.dest_start = dstart;
				case (src_adj_of(cmd_s1.ctl))
					ADJ_UP:   nxt.work_src = cur.work_src + step;
					ADJ_DOWN: nxt.work_src = cur.work_src - step;
					default:  nxt.work_src = cur.work_src;
				endcase
				if (cmd_s1.reload) begin
					nxt.work_dst = dstart;
				end else begin
					case (dst_adj_of(cmd_s1.ctl))
						ADJ_UP, ADJ_RELOAD: nxt.work_dst = cur.work_dst + step;
						ADJ_DOWN:           nxt.work_dst = cur.work_dst - step;
						default:            nxt.work_dst = cur.work_dst;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// stage 1 control and forwarding state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= OP_NONE;
			written_q   <= '0;
			fwd_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				op_s1       <= accept ? cmd.op : OP_NONE;
				out_valid_q <= (op_s1 == OP_UNIT);
			end
			if (we) begin
				written_q[ch_s1] <= 1'b1;
				fwd_ok_q         <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			ch_s1  <= cmd_ch;
		end
		if (we) begin
			fwd_addr_q <= ch_s1;
			fwd_data_q <= nxt;
		end
		if (adv && op_s1 == OP_UNIT) begin
			unit_channel  <= ch_s1;
			read_address  <= cur.work_src;
			write_address <= cur.work_dst;
			word_size     <= cmd_s1.ctl[CTL_WORD];
			last          <= cmd_s1.last;
			irq_mask      <= (cmd_s1.last && cmd_s1.ctl[CTL_IRQ]) ?
				({{(CHANNELS-1){1'b0}}, 1'b1} << ch_s1) : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/four_channel_dma_sequencer_core.sv */
// ----------------------------------------------------------------------------
// four_channel_dma_sequencer_core
// four-channel dma sequencer: register writes, blank events and step ticks in,
// one copy command per step that finds a pending channel out
// ----------------------------------------------------------------------------
// One input item is taken every unstalled cycle. A step that finds a pending
// channel sends its copy command through the stage 1 and output registers.
// The rate is set by the channel address memory: each item reads its entry
// and items that change it write it back, with the previous write forwarded
// so that items on the same channel can follow each other cycle by cycle.
// The input stalls only while a command waits in the output register and the
// output is stalled. Control, count and block length live in flip-flops.
// ----------------------------------------------------------------------------
module four_channel_dma_sequencer_core import fcds_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  kind,
	input  logic [$clog2(CHANNELS)-1:0] channel,
	input  logic [31:0]                 value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [$clog2(CHANNELS)-1:0] unit_channel,
	output logic [31:0]                 read_address,
	output logic [31:0]                 write_address,
	output logic                        word_size,
	output logic                        last,
	output logic [CHANNELS-1:0]         irq_mask
);

	logic                        accept;
	logic                        hold;
	cmd_t                        cmd;
	logic [$clog2(CHANNELS)-1:0] cmd_ch;

	assign in_stall = hold;
	assign accept   = in_valid && !hold;

	fcds_ctrl #(
		.CHANNELS(CHANNELS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (kind),
		.channel(channel),
		.value  (value),
		.cmd    (cmd),
		.cmd_ch (cmd_ch)
	);

	fcds_datapath #(
		.CHANNELS(CHANNELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.cmd_ch       (cmd_ch),
		.out_stall    (out_stall),
		.hold         (hold),
		.out_valid    (out_valid),
		.unit_channel (unit_channel),
		.read_address (read_address),
		.write_address(write_address),
		.word_size    (word_size),
		.last         (last),
		.irq_mask     (irq_mask)
	);

endmodule

/* sv/fcds_checker.sv */
// ----------------------------------------------------------------------------
// fcds_checker
// port-level checks for the dma sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcds_checker #(
	parameter int CHANNELS = 4
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [31:0]         read_address,
	input logic                last,
	input logic [CHANNELS-1:0] irq_mask
);

	// input backpressure comes only from a blocked output transfer
	`ASSERT_IMPLY(a_stall_source, clk, arst_n, 1'b1, in_stall == (out_valid && out_stall))

	// an interrupt request names one channel and only ends a block
	`ASSERT_IMPLY(a_irq_on_last, clk, arst_n, out_valid && irq_mask != '0, last && $onehot(irq_mask))

	// a blocked command stays put
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(read_address))

	// a stalled input with a blocked output keeps the output occupied
	`ASSERT_NEXT(a_stall_keeps_out, clk, arst_n, in_valid && in_stall && out_stall, out_valid)

endmodule

bind four_channel_dma_sequencer_core fcds_checker #(.CHANNELS(CHANNELS)) u_fcds_checker (.*);
